FILE: src/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, sizes and codes for the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	// Sizes of the thread table and the semaphore bank.
	localparam int NUM_THREADS = 8;
	localparam int NUM_SEMS    = 4;

	localparam int TID_W  = $clog2(NUM_THREADS);
	localparam int SCAN_W = $clog2(NUM_THREADS + 1);
	localparam int SUM_W  = TID_W + 1;
	localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

	// Item kinds.
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_YIELD  = 3'd1;
	localparam logic [2:0] KIND_WAIT   = 3'd2;
	localparam logic [2:0] KIND_SIGNAL = 3'd3;
	localparam logic [2:0] KIND_CREATE = 3'd4;
	localparam logic [2:0] KIND_EXIT   = 3'd5;

	// Result status codes.
	localparam logic [1:0] STAT_OK            = 2'd0;
	localparam logic [1:0] STAT_NONE_RUNNABLE = 2'd1;
	localparam logic [1:0] STAT_NO_SLOT       = 2'd2;
	localparam logic [1:0] STAT_SATURATED     = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_TIME_SLICE  = 1'b0;
	localparam logic CFG_SEM_INITIAL = 1'b1;

	// Semaphore count limits (signed 8 bits).
	localparam logic signed [7:0] SEM_MIN = -8'sd128;
	localparam logic signed [7:0] SEM_MAX = 8'sd127;

	typedef enum logic [1:0] {
		TS_FINISHED,
		TS_RUNNING,
		TS_READY,
		TS_BLOCKED
	} thread_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] semaphore_index;
		logic       dos_busy;
	} item_t;

	typedef struct packed {
		logic [2:0] running_id;
		logic       switched;
		logic [1:0] status;
		logic [2:0] created_id;
		logic       others_finished;
		logic       caller_blocked;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_dispatch;
		logic scan_hit;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: src/rrts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: takes one item, runs its operation, walks the dispatch scan
// when needed and hands the result to the output register.
// ----------------------------------------------------------------------------
module rrts_ctrl
	import rrts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	ctrl_state_t state_q;
	ctrl_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec   = 1'b1;
				state_next = stat.need_dispatch ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_hit || stat.scan_last) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/rrts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: thread table, tick counter, semaphores with FIFO
// wait queues, the one-slot-per-cycle dispatch scan and the result register.
// ----------------------------------------------------------------------------
module rrts_dp
	import rrts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic       cfg_valid,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       result_ready,
	output logic       result_valid,
	output result_t    result
);

	// Latched item.
	item_t item_q;

	// Scheduler state.
	thread_state_t    ts_q [NUM_THREADS];
	logic [TID_W-1:0] running_q;
	logic [7:0]       tick_q;
	logic signed [7:0] sem_q [NUM_SEMS];
	logic [TID_W-1:0] qnext_q [NUM_THREADS];
	logic [TID_W-1:0] qhead_q [NUM_SEMS];
	logic [TID_W-1:0] qtail_q [NUM_SEMS];
	logic             qne_q [NUM_SEMS];
	logic [7:0]       time_slice_q;

	// Per-item working registers.
	logic [SCAN_W-1:0] scan_q;
	logic              sw_q;
	logic [1:0]        status_q;
	logic [TID_W-1:0]  created_q;
	logic              blocked_q;

	// Result register.
	logic    result_valid_q;
	result_t result_q;

	// Derived values.
	logic              caller_runs;
	logic [7:0]        tick_inc;
	logic              sem_ok;
	logic [SEM_W-1:0]  sem_sel;
	logic signed [7:0] sem_cur;
	logic signed [7:0] wait_new;
	logic              wait_sat;
	logic              wait_blocks;
	logic signed [7:0] sig_new;
	logic              sig_sat;
	logic              sig_wakes;
	logic              free_found;
	logic [TID_W-1:0]  free_id;
	logic [SUM_W-1:0]  scan_sum;
	logic [TID_W-1:0]  scan_id;
	logic              others;
	logic              qnext_we;

	// Operation decode on the latched item.
	always_comb begin
		caller_runs = (ts_q[running_q] == TS_RUNNING);
		tick_inc    = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;
		sem_ok      = (32'(item_q.semaphore_index) < NUM_SEMS);
		sem_sel     = SEM_W'(item_q.semaphore_index);
		sem_cur     = sem_q[sem_sel];
		wait_sat    = (sem_cur == SEM_MIN);
		wait_new    = wait_sat ? sem_cur : sem_cur - 8'sd1;
		wait_blocks = wait_new[7];
		sig_sat     = (sem_cur == SEM_MAX);
		sig_new     = sig_sat ? sem_cur : sem_cur + 8'sd1;
		sig_wakes   = (sig_new[7] || (sig_new == 8'sd0)) && qne_q[sem_sel];
		qnext_we    = cmd.exec && (item_q.kind == KIND_WAIT) && caller_runs && sem_ok
			&& wait_blocks && qne_q[sem_sel];
	end

	// Lowest finished slot from 1 upward.
	always_comb begin
		free_found = 1'b0;
		free_id    = '0;
		for (int i = NUM_THREADS - 1; i >= 1; i--) begin
			if (ts_q[i] == TS_FINISHED) begin
				free_found = 1'b1;
				free_id    = TID_W'(i);
			end
		end
	end

	// All slots but slot 0 finished.
	always_comb begin
		others = 1'b1;
		for (int i = 1; i < NUM_THREADS; i++) begin
			if (ts_q[i] != TS_FINISHED) begin
				others = 1'b0;
			end
		end
	end

	// Slot under test in the dispatch scan, wrapped round the table.
	always_comb begin
		scan_sum = SUM_W'(running_q) + SUM_W'(scan_q);
		if (scan_sum >= SUM_W'(NUM_THREADS)) begin
			scan_id = TID_W'(scan_sum - SUM_W'(NUM_THREADS));
		end else begin
			scan_id = TID_W'(scan_sum);
		end
	end

	// Status to the controller.
	always_comb begin
		case (item_q.kind)
			KIND_TICK:  stat.need_dispatch = (tick_inc >= time_slice_q) && !item_q.dos_busy;
			KIND_YIELD: stat.need_dispatch = 1'b1;
			KIND_WAIT:  stat.need_dispatch = caller_runs && sem_ok && wait_blocks;
			KIND_EXIT:  stat.need_dispatch = caller_runs;
			default:    stat.need_dispatch = 1'b0;
		endcase
		stat.scan_hit  = (ts_q[scan_id] == TS_READY) || (ts_q[scan_id] == TS_RUNNING);
		stat.scan_last = (scan_q == SCAN_W'(NUM_THREADS));
		stat.out_free  = !result_valid_q || result_ready;
	end

	// Item capture and wait-queue links (no reset needed).
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (qnext_we) begin
			qnext_q[qtail_q[sem_sel]] <= running_q;
		end
	end

	// Scheduler state, operations and dispatch scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THREADS; i++) begin
				ts_q[i] <= (i == 0) ? TS_RUNNING : TS_FINISHED;
			end
			for (int i = 0; i < NUM_SEMS; i++) begin
				sem_q[i]   <= 8'sd1;
				qhead_q[i] <= '0;
				qtail_q[i] <= '0;
				qne_q[i]   <= 1'b0;
			end
			running_q    <= '0;
			tick_q       <= '0;
			time_slice_q <= 8'd1;
			scan_q       <= '0;
			sw_q         <= 1'b0;
			status_q     <= STAT_OK;
			created_q    <= '0;
			blocked_q    <= 1'b0;
		end else begin
			// Operation step.
			if (cmd.exec) begin
				sw_q      <= 1'b0;
				status_q  <= STAT_OK;
				created_q <= '0;
				blocked_q <= 1'b0;
				scan_q    <= SCAN_W'(1);
				case (item_q.kind)
					KIND_TICK: begin
						tick_q <= tick_inc;
					end
					KIND_WAIT: begin
						if (!caller_runs) begin
							status_q <= STAT_NONE_RUNNABLE;
						end else if (sem_ok) begin
							sem_q[sem_sel] <= wait_new;
							if (wait_sat) begin
								status_q <= STAT_SATURATED;
							end
							if (wait_blocks) begin
								ts_q[running_q] <= TS_BLOCKED;
								if (!qne_q[sem_sel]) begin
									qhead_q[sem_sel] <= running_q;
								end
								qtail_q[sem_sel] <= running_q;
								qne_q[sem_sel]   <= 1'b1;
								blocked_q        <= 1'b1;
							end
						end
					end
					KIND_SIGNAL: begin
						if (sem_ok) begin
							sem_q[sem_sel] <= sig_new;
							if (sig_sat) begin
								status_q <= STAT_SATURATED;
							end
							if (sig_wakes) begin
								ts_q[qhead_q[sem_sel]] <= TS_READY;
								if (qhead_q[sem_sel] == qtail_q[sem_sel]) begin
									qne_q[sem_sel] <= 1'b0;
								end else begin
									qhead_q[sem_sel] <= qnext_q[qhead_q[sem_sel]];
								end
							end
						end
					end
					KIND_CREATE: begin
						if (!free_found) begin
							status_q <= STAT_NO_SLOT;
						end else begin
							ts_q[free_id] <= TS_READY;
							created_q     <= free_id;
						end
					end
					KIND_EXIT: begin
						if (!caller_runs) begin
							status_q <= STAT_NONE_RUNNABLE;
						end else begin
							ts_q[running_q] <= TS_FINISHED;
						end
					end
					default: begin
					end
				endcase
			end

			// Dispatch scan: one slot per cycle after the running thread.
			if (cmd.scan) begin
				if (stat.scan_hit) begin
					if (ts_q[running_q] == TS_RUNNING) begin
						ts_q[running_q] <= TS_READY;
					end
					ts_q[scan_id] <= TS_RUNNING;
					sw_q          <= (scan_id != running_q);
					running_q     <= scan_id;
					tick_q        <= '0;
				end else if (stat.scan_last) begin
					status_q <= STAT_NONE_RUNNABLE;
				end else begin
					scan_q <= scan_q + SCAN_W'(1);
				end
			end

			// Configuration writes.
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TIME_SLICE: begin
						time_slice_q <= cfg_data;
					end
					CFG_SEM_INITIAL: begin
						for (int i = 0; i < NUM_SEMS; i++) begin
							sem_q[i] <= signed'({1'b0, cfg_data[6:0]});
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.running_id      <= 3'(running_q);
			result_q.switched        <= sw_q;
			result_q.status          <= status_q;
			result_q.created_id      <= 3'(created_q);
			result_q.others_finished <= others;
			result_q.caller_blocked  <= blocked_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: src/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread scheduler with round-robin dispatch, time slicing and counting
// semaphores with FIFO wait queues.
// ----------------------------------------------------------------------------
//  Channel  | Signals                              | Direction
//  ---------+--------------------------------------+----------
//  item     | item_valid, item_ready, item         | in
//  result   | result_valid, result_ready, result   | out
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | in
//
// An item passes through load, execute and finish, with the round-robin
// scan between execute and finish when a dispatch is needed; the scan
// visits 1 to NUM_THREADS slots, one slot per cycle.
// Reset: slot 0 running, others finished, every semaphore count 1.
// A new item is taken while a finished result still waits in the output
// register; a stalled result holds the sequencer before the next result.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler
	import rrts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Configuration transfers are always taken.
	assign cfg_ready = 1'b1;

	rrts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	rrts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

FILE: src/rrts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks for the round-robin thread scheduler.
// ----------------------------------------------------------------------------
module rrts_checker
	import rrts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input result_t    result
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Only one item is in work at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while one is in work");

	// A context switch only comes with a successful dispatch.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.switched |-> result.status == STAT_OK)
		else $error("switch reported with error status");

	// A created thread never comes with a switch, a block or all other slots finished.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.created_id != 3'd0)
			|-> !result.switched && !result.caller_blocked && !result.others_finished)
		else $error("create result inconsistent");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

FILE: test/sched_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sched_result_checker
// Watches the item, result and register channels of the thread scheduler.
// It keeps its own copy of the thread table, the time-slice counter and the
// semaphores, works out the result of every item when the item transfer
// happens, and compares each result transfer field by field with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module sched_result_checker
	import rrts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  result_t           result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	output int unsigned       fail_count,
	output int unsigned       outstanding,
	output int unsigned       results_seen,
	output int unsigned       switch_count,
	output int unsigned       block_count
);

	localparam int MAX_PRINTED = 40;

	// Shadow copy of the scheduler state.
	thread_state_t           slot_state [NUM_THREADS];
	logic [TID_W-1:0]        cur_thread;
	logic [7:0]              slice_ticks;
	logic signed [7:0]       sem_val    [NUM_SEMS];
	logic [TID_W-1:0]        wait_link  [NUM_THREADS];
	logic [TID_W-1:0]        wait_head  [NUM_SEMS];
	logic [TID_W-1:0]        wait_tail  [NUM_SEMS];
	logic                    wait_busy  [NUM_SEMS];
	logic [7:0]              slice_len;
	logic [6:0]              sem_reload;

	// Results predicted but not yet seen on the result channel.
	result_t                 pending_results [$];

	int unsigned             errors   = 0;
	int unsigned             checked  = 0;
	int unsigned             switches = 0;
	int unsigned             blocks   = 0;

	// Print one line for a mismatch and count it.
	task automatic report_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("[%0t] ERROR: %s", $time, msg);
	endtask

	task automatic check_field(input string field, input logic [2:0] got,
			input logic [2:0] want);
		if (got !== want)
			report_error($sformatf("result %0d: %s is %0d, expected %0d",
				checked, field, got, want));
	endtask

	task automatic reset_shadow();
		int i;
		slice_len  = 8'd1;
		sem_reload = 7'd1;
		for (i = 0; i < NUM_THREADS; i++) begin
			slot_state[i] = TS_FINISHED;
			wait_link[i]  = '0;
		end
		slot_state[0] = TS_RUNNING;
		cur_thread    = '0;
		slice_ticks   = 8'd0;
		for (i = 0; i < NUM_SEMS; i++) begin
			sem_val[i]   = 8'sd1;
			wait_head[i] = '0;
			wait_tail[i] = '0;
			wait_busy[i] = 1'b0;
		end
	endtask

	// Round-robin scan after the running slot for a ready or running slot.
	function automatic logic [1:0] pick_next_thread(output logic moved);
		int               i;
		int               idx;
		logic [TID_W-1:0] cand;
		moved = 1'b0;
		for (i = 1; i <= NUM_THREADS; i++) begin
			idx  = (int'(cur_thread) + i) % NUM_THREADS;
			cand = idx[TID_W-1:0];
			if (slot_state[cand] == TS_READY || slot_state[cand] == TS_RUNNING) begin
				if (slot_state[cur_thread] == TS_RUNNING)
					slot_state[cur_thread] = TS_READY;
				slot_state[cand] = TS_RUNNING;
				moved            = (cand != cur_thread);
				cur_thread       = cand;
				slice_ticks      = 8'd0;
				return STAT_OK;
			end
		end
		return STAT_NONE_RUNNABLE;
	endfunction

	// Apply one item to the shadow state and return the result it causes.
	function automatic result_t schedule_outcome(input item_t it);
		result_t          r;
		logic             moved;
		logic [1:0]       st;
		logic             runs;
		logic             found;
		logic [TID_W-1:0] h;
		logic [SEM_W-1:0] s;
		int               i;
		r     = '0;
		moved = 1'b0;
		st    = STAT_OK;
		found = 1'b0;
		s     = it.semaphore_index;
		runs  = (slot_state[cur_thread] == TS_RUNNING);
		case (it.kind)
			KIND_TICK: begin
				if (slice_ticks != 8'hFF)
					slice_ticks = slice_ticks + 8'd1;
				if (slice_ticks >= slice_len && !it.dos_busy)
					st = pick_next_thread(moved);
			end
			KIND_YIELD: begin
				st = pick_next_thread(moved);
			end
			KIND_WAIT: begin
				if (!runs) begin
					st = STAT_NONE_RUNNABLE;
				end else if (int'(s) < NUM_SEMS) begin
					if (sem_val[s] != SEM_MIN)
						sem_val[s] = sem_val[s] - 8'sd1;
					else
						st = STAT_SATURATED;
					// A negative count parks the caller at the tail of the queue.
					if (sem_val[s] < 0) begin
						slot_state[cur_thread] = TS_BLOCKED;
						if (wait_busy[s])
							wait_link[wait_tail[s]] = cur_thread;
						else
							wait_head[s] = cur_thread;
						wait_tail[s]     = cur_thread;
						wait_busy[s]     = 1'b1;
						r.caller_blocked = 1'b1;
						if (pick_next_thread(moved) != STAT_OK)
							st = STAT_NONE_RUNNABLE;
					end
				end
			end
			KIND_SIGNAL: begin
				if (int'(s) < NUM_SEMS) begin
					if (sem_val[s] != SEM_MAX)
						sem_val[s] = sem_val[s] + 8'sd1;
					else
						st = STAT_SATURATED;
					// Wake the oldest waiter while the count is not yet positive.
					if (sem_val[s] <= 0 && wait_busy[s]) begin
						h             = wait_head[s];
						slot_state[h] = TS_READY;
						if (wait_head[s] == wait_tail[s])
							wait_busy[s] = 1'b0;
						else
							wait_head[s] = wait_link[h];
					end
				end
			end
			KIND_CREATE: begin
				for (i = 1; i < NUM_THREADS; i++) begin
					if (!found && slot_state[i] == TS_FINISHED) begin
						found         = 1'b1;
						slot_state[i] = TS_READY;
						r.created_id  = i[2:0];
					end
				end
				if (!found)
					st = STAT_NO_SLOT;
			end
			KIND_EXIT: begin
				if (!runs) begin
					st = STAT_NONE_RUNNABLE;
				end else begin
					slot_state[cur_thread] = TS_FINISHED;
					st = pick_next_thread(moved);
				end
			end
			default: begin
			end
		endcase
		r.others_finished = 1'b1;
		for (i = 1; i < NUM_THREADS; i++)
			if (slot_state[i] != TS_FINISHED)
				r.others_finished = 1'b0;
		r.running_id = cur_thread;
		r.switched   = moved;
		r.status     = st;
		return r;
	endfunction

	// Register write: the initial count reloads every semaphore, queues stay.
	task automatic apply_write(input logic idx, input logic [7:0] value);
		int i;
		if (idx == CFG_TIME_SLICE) begin
			slice_len = value;
		end else begin
			sem_reload = value[6:0];
			for (i = 0; i < NUM_SEMS; i++)
				sem_val[i] = {1'b0, sem_reload};
		end
	endtask

	// Results are compared before a new item is predicted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			reset_shadow();
			pending_results.delete();
			fail_count   <= 0;
			outstanding  <= 0;
			results_seen <= 0;
			switch_count <= 0;
			block_count  <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (result_valid && result_ready) begin
				checked++;
				if (pending_results.size() == 0) begin
					report_error($sformatf("result %0d arrived with no item outstanding",
						checked));
				end else begin
					want = pending_results.pop_front();
					check_field("running_id", result.running_id, want.running_id);
					check_field("switched", result.switched, want.switched);
					check_field("status", result.status, want.status);
					check_field("created_id", result.created_id, want.created_id);
					check_field("others_finished", result.others_finished,
						want.others_finished);
					check_field("caller_blocked", result.caller_blocked,
						want.caller_blocked);
					if (want.switched)
						switches++;
					if (want.caller_blocked)
						blocks++;
				end
			end
			if (item_valid && item_ready)
				pending_results.push_back(schedule_outcome(item));
			fail_count   <= errors;
			outstanding  <= pending_results.size();
			results_seen <= checked;
			switch_count <= switches;
			block_count  <= blocks;
		end
	end

endmodule

FILE: test/tb_round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler
// Drives the thread scheduler with a short directed sequence and then random
// scheduling traffic under several time-slice and semaphore settings, with
// random gaps on the item and result channels. A checker beside the block
// predicts and compares every result; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_round_robin_thread_scheduler;
	import rrts_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 800000;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          NUM_PHASES   = 8;
	localparam int          PHASE_ITEMS  = 105;

	// Kinds the block has no use for; they must pass through untouched.
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned results_seen;
	int unsigned switch_count;
	int unsigned block_count;

	int unsigned cycle_count    = 0;
	int unsigned calm_left      = 0;
	int unsigned items_sent     = 0;
	int unsigned settings_count = 1;

	round_robin_thread_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	sched_result_checker u_result_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.switch_count (switch_count),
		.block_count  (block_count)
	);

	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Idle length: mostly none or short, a few long, and now and then a calm
	// stretch with no idling at all.
	function automatic int unsigned draw_gap();
		int unsigned roll;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: accept in runs, with random stalls in between.
	initial begin : result_sink
		int unsigned stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = draw_gap();
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// One item transfer; valid stays high across back-to-back items.
	task automatic push_item(input logic [2:0] kind, input logic [1:0] sem,
			input logic busy);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid           <= 1'b1;
		item.kind            <= kind;
		item.semaphore_index <= sem;
		item.dos_busy        <= busy;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// Weighted mix of scheduling operations with random operands.
	task automatic push_random_item();
		int unsigned roll;
		logic [2:0]  kind;
		roll = $urandom_range(0, 99);
		if (roll < 24)
			kind = KIND_TICK;
		else if (roll < 32)
			kind = KIND_YIELD;
		else if (roll < 52)
			kind = KIND_WAIT;
		else if (roll < 72)
			kind = KIND_SIGNAL;
		else if (roll < 84)
			kind = KIND_CREATE;
		else if (roll < 95)
			kind = KIND_EXIT;
		else
			kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;
		push_item(kind, 2'($urandom_range(0, 3)), ($urandom_range(0, 9) < 3));
	endtask

	// Stop sending and wait until every predicted result has been taken.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int          phase;
		int          n;
		logic [7:0]  slice;
		logic [6:0]  init_count;

		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_TIME_SLICE;
		cfg_data   = 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: busy tick, yield, creation until the
		// table is full, a wait that blocks and the signal that wakes it, the
		// unused kinds, and exits until no thread is left to run.
		push_item(KIND_TICK, 2'd0, 1'b1);
		push_item(KIND_YIELD, 2'd0, 1'b0);
		push_item(KIND_CREATE, 2'd0, 1'b0);
		push_item(KIND_CREATE, 2'd0, 1'b0);
		push_item(KIND_TICK, 2'd3, 1'b0);
		push_item(KIND_WAIT, 2'd0, 1'b0);
		push_item(KIND_WAIT, 2'd0, 1'b0);
		push_item(KIND_SIGNAL, 2'd0, 1'b0);
		for (n = 0; n < 6; n++)
			push_item(KIND_CREATE, 2'd1, 1'b0);
		push_item(KIND_SPARE_LO, 2'd2, 1'b0);
		push_item(KIND_SPARE_HI, 2'd3, 1'b1);
		for (n = 0; n < NUM_THREADS + 1; n++)
			push_item(KIND_EXIT, 2'd2, 1'b0);
		push_item(KIND_WAIT, 2'd1, 1'b0);
		push_item(KIND_CREATE, 2'd0, 1'b0);

		// Random phases, each under its own register setting.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			case (phase)
				0: begin
					slice = 8'd255;
					init_count = 7'd0;
				end
				1: begin
					slice = 8'd1;
					init_count = 7'd127;
				end
				2: begin
					slice = 8'd2;
					init_count = 7'd3;
				end
				3: begin
					slice = 8'd255;
					init_count = 7'd127;
				end
				4: begin
					slice = 8'd1;
					init_count = 7'd0;
				end
				5: begin
					slice = 8'($urandom_range(1, 255));
					init_count = 7'($urandom_range(0, 127));
				end
				default: begin
					slice = 8'($urandom_range(1, 6));
					init_count = 7'($urandom_range(0, 4));
				end
			endcase
			write_reg(CFG_TIME_SLICE, slice);
			write_reg(CFG_SEM_INITIAL, {1'b0, init_count});
			settings_count++;

			// With the longest slice, a long run of busy ticks drives the tick
			// counter into saturation before a free tick may dispatch.
			if (phase == 0) begin
				for (n = 0; n < 270; n++)
					push_item(KIND_TICK, 2'($urandom_range(0, 3)), 1'b1);
				push_item(KIND_TICK, 2'd0, 1'b0);
			end
			for (n = 0; n < PHASE_ITEMS; n++)
				push_random_item();
		end

		settle();
		$display("Sent %0d items under %0d register settings; %0d results checked.",
			items_sent, settings_count, results_seen);
		$display("Predicted and checked %0d context switches and %0d blocking waits.",
			switch_count, block_count);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
